FILE: sv/idct8_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the Q15 multiply function for the 8-point IDCT block.
// No dependencies; every other file of the block imports this package.

package idct8_pkg;

    localparam int DataW     = 16;
    localparam int QShift    = 15;
    localparam int NumCos    = 7;
    localparam int CfgIdxW   = 3;
    localparam int NumPts    = 8;
    localparam int NumStages = 4;

    typedef logic signed [DataW-1:0] word_t;
    typedef word_t vec8_t [NumPts];

    // Register indexes of the configuration port.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_COS_1 = 3'd0,
        CFG_COS_2 = 3'd1,
        CFG_COS_3 = 3'd2,
        CFG_COS_4 = 3'd3,
        CFG_COS_5 = 3'd4,
        CFG_COS_6 = 3'd5,
        CFG_COS_7 = 3'd6
    } cfg_idx_t;

    // Reset values: round(cos(k*pi/16) * 2^15) for k = 1..7.
    localparam word_t CosRst [NumCos] = '{
        16'sd32138, 16'sd30274, 16'sd27246, 16'sd23170,
        16'sd18205, 16'sd12540, 16'sd6393
    };

    // Rounding constant added before the Q15 shift.
    localparam logic signed [2*DataW-1:0] QRound = (2*DataW)'(1) <<< (QShift - 1);

    // Cosine words plus the halved sum of cos_2 and cos_6 used by both rotations.
    typedef struct packed {
        word_t c1;
        word_t c2;
        word_t c3;
        word_t c4;
        word_t c5;
        word_t c6;
        word_t c7;
        word_t half;
    } cos_cfg_t;

    // Stage 1: all first-level Q15 products.
    typedef struct packed {
        word_t p1r;
        word_t p1i;
        word_t p7r;
        word_t p7i;
        word_t p3r;
        word_t p3i;
        word_t p5r;
        word_t p5i;
        word_t e0;
        word_t e4;
        word_t t1e;
        word_t t2e;
        word_t t3e;
    } s1_t;

    // Stage 2: odd sums, even butterfly and even rotation outputs.
    typedef struct packed {
        word_t q1r;
        word_t q1i;
        word_t q5r;
        word_t q5i;
        word_t s0;
        word_t s4;
        word_t e2;
        word_t e6;
    } s2_t;

    // Stage 3: odd rotation products and the terms carried alongside.
    typedef struct packed {
        word_t t1o;
        word_t t2o;
        word_t t3o;
        word_t q1r;
        word_t q1i;
        word_t s0;
        word_t s4;
        word_t e2;
        word_t e6;
    } s3_t;

    // (a*b + 2^14) >>> 15, cut to 16 bits.
    function automatic word_t qmul(input word_t a, input word_t b);
        logic signed [2*DataW-1:0] p;
        p = a * b + QRound;
        return p[QShift+DataW-1:QShift];
    endfunction

endpackage

FILE: sv/idct8_q15_butterfly_unit.sv
`timescale 1ns / 1ps
// Top level of the 8-point Q15 inverse DCT: cosine registers, pipeline control, stages.
// Depends on idct8_pkg and the four idct8_*_stage modules.
//
//  Channel  | Handshake               | Payload
//  ---------+-------------------------+-----------------------------------
//  coef     | coef_valid / coef_ready | coef_0 .. coef_7, signed 16-bit
//  sample   | sample_valid / sample_ready | sample_0 .. sample_7, signed 16-bit
//  cfg      | cfg_valid / cfg_ready   | cfg_index (3 bits), cfg_data (16 bits)
//
// One request per cycle enters unless a stall on the sample side holds the pipeline; its
// samples are registered in each stage in turn before they reach the output register.
// The four register stages are: products, sums, odd rotation products, final butterflies.
// Reset clears the stage valid bits and loads the cosine words with their nominal values.
// A stall on the sample side backs up stage by stage; coef_ready falls only when all
// four stages hold a request. cfg_ready is always high.

module idct8_q15_butterfly_unit (
    input  logic             clk,
    input  logic             rst_n,

    input  logic             coef_valid,
    output logic             coef_ready,
    input  idct8_pkg::word_t coef_0,
    input  idct8_pkg::word_t coef_1,
    input  idct8_pkg::word_t coef_2,
    input  idct8_pkg::word_t coef_3,
    input  idct8_pkg::word_t coef_4,
    input  idct8_pkg::word_t coef_5,
    input  idct8_pkg::word_t coef_6,
    input  idct8_pkg::word_t coef_7,

    output logic             sample_valid,
    input  logic             sample_ready,
    output idct8_pkg::word_t sample_0,
    output idct8_pkg::word_t sample_1,
    output idct8_pkg::word_t sample_2,
    output idct8_pkg::word_t sample_3,
    output idct8_pkg::word_t sample_4,
    output idct8_pkg::word_t sample_5,
    output idct8_pkg::word_t sample_6,
    output idct8_pkg::word_t sample_7,

    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [idct8_pkg::CfgIdxW-1:0] cfg_index,
    input  idct8_pkg::word_t cfg_data
);
    import idct8_pkg::*;

    word_t                 cos_reg [NumCos];
    cos_cfg_t              cfg;
    logic signed [DataW:0] cos26_sum;
    logic signed [DataW:0] cos26_adj;

    logic [NumStages-1:0]  stage_valid_reg;
    logic [NumStages-1:0]  stage_en;
    logic [NumStages-1:0]  stage_in_valid;
    logic [NumStages-1:0]  stage_load;
    logic                  in_acc;
    logic                  out_acc;

    vec8_t                 coef;
    vec8_t                 sample;
    s1_t                   s1;
    s2_t                   s2;
    s3_t                   s3;

    // Cosine register file; writes to the unused index are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumCos; i++)
            begin
                cos_reg[i] <= CosRst[i];
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_COS_1: cos_reg[0] <= cfg_data;
                CFG_COS_2: cos_reg[1] <= cfg_data;
                CFG_COS_3: cos_reg[2] <= cfg_data;
                CFG_COS_4: cos_reg[3] <= cfg_data;
                CFG_COS_5: cos_reg[4] <= cfg_data;
                CFG_COS_6: cos_reg[5] <= cfg_data;
                CFG_COS_7: cos_reg[6] <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Halved sum of cos_2 and cos_6 at 17 bits, rounded toward zero.
    always_comb
    begin
        cos26_sum = {cos_reg[1][DataW-1], cos_reg[1]} + {cos_reg[5][DataW-1], cos_reg[5]};
        cos26_adj = cos26_sum + (DataW+1)'(cos26_sum[DataW]);
        cfg.c1    = cos_reg[0];
        cfg.c2    = cos_reg[1];
        cfg.c3    = cos_reg[2];
        cfg.c4    = cos_reg[3];
        cfg.c5    = cos_reg[4];
        cfg.c6    = cos_reg[5];
        cfg.c7    = cos_reg[6];
        cfg.half  = cos26_adj[DataW:1];
    end

    // A stage may advance when it is empty or the stage after it advances.
    always_comb
    begin
        stage_en[NumStages-1] = !stage_valid_reg[NumStages-1] || sample_ready;
        for (int k = NumStages - 2; k >= 0; k--)
        begin
            stage_en[k] = !stage_valid_reg[k] || stage_en[k+1];
        end
    end

    assign stage_in_valid = {stage_valid_reg[NumStages-2:0], coef_valid};
    assign stage_load     = stage_en & stage_in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NumStages; k++)
            begin
                if (stage_en[k])
                begin
                    stage_valid_reg[k] <= stage_in_valid[k];
                end
            end
        end
    end

    assign coef_ready   = stage_en[0];
    assign sample_valid = stage_valid_reg[NumStages-1];
    assign in_acc       = coef_valid && coef_ready;
    assign out_acc      = sample_valid && sample_ready;

    // Datapath stages.
    assign coef[0] = coef_0;
    assign coef[1] = coef_1;
    assign coef[2] = coef_2;
    assign coef[3] = coef_3;
    assign coef[4] = coef_4;
    assign coef[5] = coef_5;
    assign coef[6] = coef_6;
    assign coef[7] = coef_7;

    idct8_mul_stage u_mul (
        .clk  (clk),
        .load (stage_load[0]),
        .coef (coef),
        .cfg  (cfg),
        .s1   (s1)
    );

    idct8_sum_stage u_sum (
        .clk  (clk),
        .load (stage_load[1]),
        .s1   (s1),
        .s2   (s2)
    );

    idct8_rot_stage u_rot (
        .clk  (clk),
        .load (stage_load[2]),
        .s2   (s2),
        .cfg  (cfg),
        .s3   (s3)
    );

    idct8_out_stage u_out (
        .clk    (clk),
        .load   (stage_load[3]),
        .s3     (s3),
        .sample (sample)
    );

    assign sample_0 = sample[0];
    assign sample_1 = sample[1];
    assign sample_2 = sample[2];
    assign sample_3 = sample[3];
    assign sample_4 = sample[4];
    assign sample_5 = sample[5];
    assign sample_6 = sample[6];
    assign sample_7 = sample[7];

    // An accepted request always occupies the first stage on the next cycle.
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> stage_valid_reg[0])
        else $error("accepted request did not enter the first stage");

    // With every stage full and the output stalled, no request may be taken.
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (&stage_valid_reg && !sample_ready) |-> !coef_ready)
        else $error("request accepted while the pipeline is full and stalled");

    // Requests in flight change only by what enters and what leaves.
    a_count_kept: assert property (@(posedge clk) disable iff (!rst_n)
        rst_n |=> ($countones(stage_valid_reg) ==
                   $past($countones(stage_valid_reg)) + $past(in_acc) - $past(out_acc)))
        else $error("request lost or duplicated inside the pipeline");

endmodule

FILE: sv/idct8_mul_stage.sv
`timescale 1ns / 1ps
// First pipeline stage: forms every Q15 product that depends only on the coefficients.
// Depends on idct8_pkg.

module idct8_mul_stage (
    input  logic               clk,
    input  logic               load,
    input  idct8_pkg::vec8_t   coef,
    input  idct8_pkg::cos_cfg_t cfg,
    output idct8_pkg::s1_t     s1
);
    import idct8_pkg::*;

    s1_t   s1_reg;
    s1_t   s1_next;
    word_t d26;

    // Odd-term products, even scaling and the three even-rotation multiplies.
    always_comb
    begin
        d26           = coef[2] + coef[6];
        s1_next.p1r   = qmul(cfg.c1, coef[1]);
        s1_next.p1i   = qmul(cfg.c7, coef[1]);
        s1_next.p7r   = qmul(cfg.c7, coef[7]);
        s1_next.p7i   = qmul(cfg.c1, coef[7]);
        s1_next.p3r   = qmul(cfg.c3, coef[3]);
        s1_next.p3i   = qmul(cfg.c5, coef[3]);
        s1_next.p5r   = qmul(cfg.c5, coef[5]);
        s1_next.p5i   = qmul(cfg.c3, coef[5]);
        s1_next.e0    = qmul(coef[0], cfg.c4);
        s1_next.e4    = qmul(coef[4], cfg.c4);
        s1_next.t1e   = qmul(coef[2], cfg.c6);
        s1_next.t2e   = qmul(coef[6], cfg.c2);
        s1_next.t3e   = qmul(d26, cfg.half);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

FILE: sv/idct8_sum_stage.sv
`timescale 1ns / 1ps
// Second pipeline stage: odd-term sums, even butterfly and even rotation outputs.
// Depends on idct8_pkg.

module idct8_sum_stage (
    input  logic           clk,
    input  logic           load,
    input  idct8_pkg::s1_t s1,
    output idct8_pkg::s2_t s2
);
    import idct8_pkg::*;

    s2_t s2_reg;
    s2_t s2_next;

    // All sums wrap at 16 bits.
    always_comb
    begin
        s2_next.q1r = s1.p1r + s1.p5r + s1.p7r + s1.p3r;
        s2_next.q1i = s1.p1i + s1.p5i - s1.p7i - s1.p3i;
        s2_next.q5r = s1.p1r - s1.p5i - s1.p7r - s1.p3i;
        s2_next.q5i = s1.p1i + s1.p5r + s1.p7i - s1.p3r;
        s2_next.s0  = s1.e0 + s1.e4;
        s2_next.s4  = s1.e0 - s1.e4;
        s2_next.e6  = s1.t1e - s1.t2e;
        s2_next.e2  = s1.t3e + s1.t3e - s1.t1e - s1.t2e;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2 = s2_reg;

endmodule

FILE: sv/idct8_rot_stage.sv
`timescale 1ns / 1ps
// Third pipeline stage: the three multiplies of the odd-term rotation.
// Depends on idct8_pkg.

module idct8_rot_stage (
    input  logic                clk,
    input  logic                load,
    input  idct8_pkg::s2_t      s2,
    input  idct8_pkg::cos_cfg_t cfg,
    output idct8_pkg::s3_t      s3
);
    import idct8_pkg::*;

    s3_t   s3_reg;
    s3_t   s3_next;
    word_t q5sum;

    // Rotate (q5r, q5i) by (cos_2, cos_6); the other terms ride along.
    always_comb
    begin
        q5sum       = s2.q5r + s2.q5i;
        s3_next.t1o = qmul(s2.q5r, cfg.c2);
        s3_next.t2o = qmul(s2.q5i, cfg.c6);
        s3_next.t3o = qmul(q5sum, cfg.half);
        s3_next.q1r = s2.q1r;
        s3_next.q1i = s2.q1i;
        s3_next.s0  = s2.s0;
        s3_next.s4  = s2.s4;
        s3_next.e2  = s2.e2;
        s3_next.e6  = s2.e6;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s3_reg <= s3_next;
        end
    end

    assign s3 = s3_reg;

endmodule

FILE: sv/idct8_out_stage.sv
`timescale 1ns / 1ps
// Last pipeline stage: finishes the odd rotation and forms the eight samples.
// Depends on idct8_pkg; its registers are the block's output register.

module idct8_out_stage (
    input  logic           clk,
    input  logic           load,
    input  idct8_pkg::s3_t s3,
    output idct8_pkg::vec8_t sample
);
    import idct8_pkg::*;

    vec8_t sample_reg;
    vec8_t sample_next;
    word_t q5r;
    word_t q5i;

    // Rotation outputs, then the final butterflies; everything wraps at 16 bits.
    always_comb
    begin
        q5r            = s3.t1o - s3.t2o;
        q5i            = s3.t3o + s3.t3o - s3.t1o - s3.t2o;
        sample_next[0] = s3.s0 + s3.q1r + s3.e2;
        sample_next[1] = s3.s4 + q5r + s3.e6;
        sample_next[2] = s3.s4 + q5i - s3.e6;
        sample_next[3] = s3.s0 + s3.q1i - s3.e2;
        sample_next[4] = s3.s0 - s3.q1i - s3.e2;
        sample_next[5] = s3.s4 - q5i - s3.e6;
        sample_next[6] = s3.s4 - q5r + s3.e6;
        sample_next[7] = s3.s0 - s3.q1r + s3.e2;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sample_reg <= sample_next;
        end
    end

    assign sample = sample_reg;

endmodule

FILE: dv/idct8_checker.sv
`timescale 1ns / 1ps
// Checker for the 8-point Q15 inverse DCT: watches the three channels and predicts each sample set.
// Depends on idct8_pkg for the word type and the register indexes.

module idct8_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          coef_valid,
    input  logic                          coef_ready,
    input  idct8_pkg::word_t              coef_0,
    input  idct8_pkg::word_t              coef_1,
    input  idct8_pkg::word_t              coef_2,
    input  idct8_pkg::word_t              coef_3,
    input  idct8_pkg::word_t              coef_4,
    input  idct8_pkg::word_t              coef_5,
    input  idct8_pkg::word_t              coef_6,
    input  idct8_pkg::word_t              coef_7,
    input  logic                          sample_valid,
    input  logic                          sample_ready,
    input  idct8_pkg::word_t              sample_0,
    input  idct8_pkg::word_t              sample_1,
    input  idct8_pkg::word_t              sample_2,
    input  idct8_pkg::word_t              sample_3,
    input  idct8_pkg::word_t              sample_4,
    input  idct8_pkg::word_t              sample_5,
    input  idct8_pkg::word_t              sample_6,
    input  idct8_pkg::word_t              sample_7,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [idct8_pkg::CfgIdxW-1:0] cfg_index,
    input  idct8_pkg::word_t              cfg_data,
    output int                            fail_count,
    output int                            outstanding,
    output int                            results_checked
);

    import idct8_pkg::*;

    typedef logic [NumPts-1:0][DataW-1:0] frame_t;

    // Nominal Q15 cosine words loaded by reset.
    localparam int CosNominal [NumCos] = '{32138, 30274, 27246, 23170, 18205, 12540, 6393};

    int     cos_word [NumCos];
    frame_t sample_sets_due [$];
    int     errors;
    int     queued;
    int     checked;

    assign fail_count      = errors;
    assign outstanding     = queued;
    assign results_checked = checked;

    initial
    begin
        errors  = 0;
        queued  = 0;
        checked = 0;
    end

    // Cut to 16 bits and sign-extend back to an int.
    function automatic int to_word(input int x);
        logic signed [DataW-1:0] w;
        w = x[DataW-1:0];
        return int'(w);
    endfunction

    // Q15 product with round-half-up and a floor shift.
    function automatic int q15_mul(input int a, input int b);
        int p;
        p = a * b + (1 <<< (QShift - 1));
        return to_word(p >>> QShift);
    endfunction

    // Three-multiply complex rotation; the multiplier half-sum truncates toward zero.
    function automatic void rotate3(input int ar, input int ai, input int br, input int bi,
                                    output int re, output int im);
        int t1;
        int t2;
        int t3;
        int half;
        t1   = q15_mul(ar, br);
        t2   = q15_mul(ai, bi);
        half = (br + bi) / 2;
        t3   = q15_mul(to_word(ar + ai), to_word(half));
        re   = to_word(t1 - t2);
        im   = to_word(2 * t3 - t1 - t2);
    endfunction

    // Full transform of one coefficient vector with the current cosine words.
    function automatic frame_t idct_samples(input frame_t c);
        int     d [NumPts];
        int     y [NumPts];
        int     p1r, p1i, p7r, p7i, p3r, p3i, p5r, p5i;
        int     q1r, q1i, q5r, q5i, r5r, r5i;
        int     e0, e4, s0, s4, e2, e6;
        frame_t r;
        for (int i = 0; i < NumPts; i++)
        begin
            d[i] = int'($signed(c[i]));
        end

        p1r = q15_mul(cos_word[0], d[1]);
        p1i = q15_mul(cos_word[6], d[1]);
        p7r = q15_mul(cos_word[6], d[7]);
        p7i = q15_mul(cos_word[0], d[7]);
        p3r = q15_mul(cos_word[2], d[3]);
        p3i = q15_mul(cos_word[4], d[3]);
        p5r = q15_mul(cos_word[4], d[5]);
        p5i = q15_mul(cos_word[2], d[5]);

        q1r = to_word(p1r + p5r + p7r + p3r);
        q1i = to_word(p1i + p5i - p7i - p3i);
        q5r = to_word(p1r - p5i - p7r - p3i);
        q5i = to_word(p1i + p5r + p7i - p3r);
        rotate3(q5r, q5i, cos_word[1], cos_word[5], r5r, r5i);

        e0 = q15_mul(d[0], cos_word[3]);
        e4 = q15_mul(d[4], cos_word[3]);
        s0 = to_word(e0 + e4);
        s4 = to_word(e0 - e4);
        rotate3(d[2], d[6], cos_word[5], cos_word[1], e6, e2);

        // Final butterflies wrap only at the output.
        y[0] = s0 + q1r + e2;
        y[1] = s4 + r5r + e6;
        y[2] = s4 + r5i - e6;
        y[3] = s0 + q1i - e2;
        y[4] = s0 - q1i - e2;
        y[5] = s4 - r5i - e6;
        y[6] = s4 - r5r + e6;
        y[7] = s0 - q1r + e2;
        for (int i = 0; i < NumPts; i++)
        begin
            r[i] = y[i][DataW-1:0];
        end
        return r;
    endfunction

    // Compare results first, then record new requests, then apply register writes.
    always @(posedge clk or negedge rst_n)
    begin
        frame_t got;
        frame_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < NumCos; k++)
            begin
                cos_word[k] = CosNominal[k];
            end
            sample_sets_due.delete();
            queued = 0;
        end
        else
        begin
            if (sample_valid && sample_ready)
            begin
                got = {sample_7, sample_6, sample_5, sample_4,
                       sample_3, sample_2, sample_1, sample_0};
                if (sample_sets_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected sample set, expected none, got %h",
                             $time, got);
                end
                else
                begin
                    want = sample_sets_due.pop_front();
                    checked++;
                    for (int i = 0; i < NumPts; i++)
                    begin
                        if (got[i] !== want[i])
                        begin
                            errors++;
                            $display("%0t: sample_%0d expected %0d, got %0d", $time, i,
                                     $signed(want[i]), $signed(got[i]));
                        end
                    end
                end
            end

            if (coef_valid && coef_ready)
            begin
                sample_sets_due.push_back(idct_samples({coef_7, coef_6, coef_5, coef_4,
                                                        coef_3, coef_2, coef_1, coef_0}));
            end

            // Index seven is not a register; writes to it are dropped.
            if (cfg_valid && cfg_ready && cfg_index < NumCos)
            begin
                cos_word[cfg_index] = int'(cfg_data);
            end

            queued = sample_sets_due.size();
        end
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Top of the IDCT testbench: clock, reset, coefficient and cosine-register stimulus, verdict.
// Depends on idct8_pkg, idct8_q15_butterfly_unit and idct8_checker.

module tb_top;

    import idct8_pkg::*;

    // Slowest run: ~670 requests with the longest gaps and the longest stalls, taken several times over.
    localparam int unsigned CycleLimit = 500000;
    localparam word_t WordMax = 16'sh7fff;
    localparam word_t WordMin = 16'sh8000;
    // The one index of the port that maps to no register.
    localparam logic [CfgIdxW-1:0] CfgSpare = 3'd7;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  coef_valid = 1'b0;
    logic  coef_ready;
    word_t coef_0 = '0;
    word_t coef_1 = '0;
    word_t coef_2 = '0;
    word_t coef_3 = '0;
    word_t coef_4 = '0;
    word_t coef_5 = '0;
    word_t coef_6 = '0;
    word_t coef_7 = '0;
    logic  sample_valid;
    logic  sample_ready = 1'b0;
    word_t sample_0;
    word_t sample_1;
    word_t sample_2;
    word_t sample_3;
    word_t sample_4;
    word_t sample_5;
    word_t sample_6;
    word_t sample_7;
    logic  cfg_valid = 1'b0;
    logic  cfg_ready;
    logic [CfgIdxW-1:0] cfg_index = '0;
    word_t cfg_data = '0;

    int fail_count;
    int outstanding;
    int results_checked;
    int coef_mode = 0;
    int ready_mode = 0;
    int stall_left = 0;
    int vectors_sent = 0;
    int settings_used = 1;
    int unsigned cycle_count = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    idct8_q15_butterfly_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .coef_valid   (coef_valid),
        .coef_ready   (coef_ready),
        .coef_0       (coef_0),
        .coef_1       (coef_1),
        .coef_2       (coef_2),
        .coef_3       (coef_3),
        .coef_4       (coef_4),
        .coef_5       (coef_5),
        .coef_6       (coef_6),
        .coef_7       (coef_7),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_0     (sample_0),
        .sample_1     (sample_1),
        .sample_2     (sample_2),
        .sample_3     (sample_3),
        .sample_4     (sample_4),
        .sample_5     (sample_5),
        .sample_6     (sample_6),
        .sample_7     (sample_7),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    idct8_checker i_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .coef_valid      (coef_valid),
        .coef_ready      (coef_ready),
        .coef_0          (coef_0),
        .coef_1          (coef_1),
        .coef_2          (coef_2),
        .coef_3          (coef_3),
        .coef_4          (coef_4),
        .coef_5          (coef_5),
        .coef_6          (coef_6),
        .coef_7          (coef_7),
        .sample_valid    (sample_valid),
        .sample_ready    (sample_ready),
        .sample_0        (sample_0),
        .sample_1        (sample_1),
        .sample_2        (sample_2),
        .sample_3        (sample_3),
        .sample_4        (sample_4),
        .sample_5        (sample_5),
        .sample_6        (sample_6),
        .sample_7        (sample_7),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    // Idle length: mode zero never idles, the others are mostly short with a few long ones.
    function automatic int pick_gap(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 30);
        return (r < 40) ? 0 : (r < 85) ? $urandom_range(1, 4) : $urandom_range(8, 30);
    endfunction

    // Coefficient value weighted toward the extremes and small magnitudes.
    function automatic word_t rand_coef();
        case ($urandom_range(0, 7))
            0: return WordMax;
            1: return WordMin;
            2, 3: return word_t'($urandom_range(0, 1023)) - 16'sd512;
            default: return word_t'($urandom);
        endcase
    endfunction

    // Sample-side back-pressure.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left > 0)
        begin
            sample_ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            sample_ready <= 1'b1;
            if (ready_mode != 0 && $urandom_range(0, 3) == 0)
                stall_left <= pick_gap(ready_mode);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offer one request and wait for it; valid stays high when the next one follows at once.
    task automatic push_coef(input vec8_t v);
        int gap;
        coef_valid <= 1'b1;
        coef_0 <= v[0];
        coef_1 <= v[1];
        coef_2 <= v[2];
        coef_3 <= v[3];
        coef_4 <= v[4];
        coef_5 <= v[5];
        coef_6 <= v[6];
        coef_7 <= v[7];
        do @(posedge clk); while (!coef_ready);
        vectors_sent++;
        gap = pick_gap(coef_mode);
        if (gap > 0)
        begin
            coef_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every sample set has come back.
    task automatic drain_all();
        coef_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_cos(input logic [CfgIdxW-1:0] idx, input word_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Load all seven cosine words once the pipeline is empty.
    task automatic retune(input word_t c1, input word_t c2, input word_t c3, input word_t c4,
                          input word_t c5, input word_t c6, input word_t c7);
        drain_all();
        write_cos(CFG_COS_1, c1);
        write_cos(CFG_COS_2, c2);
        write_cos(CFG_COS_3, c3);
        write_cos(CFG_COS_4, c4);
        write_cos(CFG_COS_5, c5);
        write_cos(CFG_COS_6, c6);
        write_cos(CFG_COS_7, c7);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Random requests, mostly dense vectors and some sparse ones, with a full pause midway.
    task automatic run_random(input int count);
        vec8_t v;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                coef_mode  = $urandom_range(0, 2);
                ready_mode = $urandom_range(0, 2);
            end
            if (n == count / 2)
                drain_all();
            if ($urandom_range(0, 4) == 0)
            begin
                v = '{default: '0};
                v[$urandom_range(0, 7)] = rand_coef();
                v[$urandom_range(0, 7)] = rand_coef();
            end
            else
            begin
                for (int i = 0; i < NumPts; i++)
                begin
                    v[i] = rand_coef();
                end
            end
            push_coef(v);
        end
    endtask

    // Directed vectors: zeros, wrap-around extremes, alternating signs, impulses, rounding.
    task automatic run_directed();
        vec8_t v;
        v = '{default: '0};
        push_coef(v);
        v = '{default: WordMax};
        push_coef(v);
        v = '{default: WordMin};
        push_coef(v);
        for (int i = 0; i < NumPts; i++)
        begin
            v[i] = (i % 2 == 0) ? WordMax : WordMin;
        end
        push_coef(v);
        for (int i = 0; i < NumPts; i++)
        begin
            v[i] = (i % 2 == 0) ? WordMin : WordMax;
        end
        push_coef(v);
        for (int k = 0; k < NumPts; k++)
        begin
            v = '{default: '0};
            v[k] = (k % 2 == 0) ? WordMin : WordMax;
            push_coef(v);
        end
        v = '{default: -16'sd1};
        push_coef(v);
        v = '{default: 16'sd1};
        push_coef(v);
        v = '{default: '0};
        v[0] = 16'sd1000;
        push_coef(v);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(100);

        retune(WordMax, WordMax, WordMax, WordMax, WordMax, WordMax, WordMax);
        run_random(80);

        retune(WordMin, WordMin, WordMin, WordMin, WordMin, WordMin, WordMin);
        run_random(80);

        // Odd negative half-sum of cos_2 and cos_6 checks truncation toward zero.
        retune(rand_coef(), WordMin, rand_coef(), rand_coef(), rand_coef(), -16'sd32767,
               rand_coef());
        run_random(80);

        retune(word_t'($urandom), word_t'($urandom), word_t'($urandom), word_t'($urandom),
               word_t'($urandom), word_t'($urandom), word_t'($urandom));
        run_random(80);

        retune(word_t'($urandom), word_t'($urandom), word_t'($urandom), word_t'($urandom),
               word_t'($urandom), word_t'($urandom), word_t'($urandom));
        run_random(80);

        // Back to nominal words, then a write to the spare index that must change nothing.
        retune(16'sd32138, 16'sd30274, 16'sd27246, 16'sd23170, 16'sd18205, 16'sd12540,
               16'sd6393);
        @(posedge clk);
        write_cos(CfgSpare, WordMin);
        cfg_valid <= 1'b0;
        run_random(150);

        drain_all();
        repeat (12) @(posedge clk);

        $display("Run covered %0d coefficient vectors and %0d checked sample sets",
                 vectors_sent, results_checked);
        $display("under %0d cosine settings, extremes and a spare-index write included.",
                 settings_used);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
